FILE: design/mtdz_pkg.sv
// types, event codes and slot record layout for the multitouch dead zone filter
package mtdz_pkg;

    localparam logic [4:0] T_SYN = 5'd0;
    localparam logic [4:0] T_KEY = 5'd1;
    localparam logic [4:0] T_ABS = 5'd3;

    localparam logic [9:0] C_SYN_REPORT = 10'h000;
    localparam logic [9:0] C_SLOT   = 10'h02F;
    localparam logic [9:0] C_TMAJ   = 10'h030;
    localparam logic [9:0] C_TMIN   = 10'h031;
    localparam logic [9:0] C_WMAJ   = 10'h032;
    localparam logic [9:0] C_WMIN   = 10'h033;
    localparam logic [9:0] C_ORIENT = 10'h034;
    localparam logic [9:0] C_PX     = 10'h035;
    localparam logic [9:0] C_PY     = 10'h036;
    localparam logic [9:0] C_TRACK  = 10'h039;
    localparam logic [9:0] C_PRESS  = 10'h03A;
    localparam logic [9:0] C_DIST   = 10'h03B;
    localparam logic [9:0] K_TOUCH  = 10'h14A;

    localparam int TOOL_KINDS = 5;
    localparam int MAX_RES = 4;
    localparam int CAND_N = 8;

    localparam logic [31:0] TRACK_RELEASE = 32'hFFFF_FFFF;

    localparam logic [1:0] REG_LEFT  = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_TOP   = 2'd2;

    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_PENDING  = 2'd1,
        MODE_LIVE     = 2'd2,
        MODE_BLOCKED  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] track_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        have_x;
        logic        have_y;
        logic        emitted;
    } slot_rec_t;

    typedef struct packed {
        logic [4:0]  ev_type;
        logic [9:0]  ev_code;
        logic [31:0] ev_value;
    } event_t;

    function automatic logic [9:0] tool_code(input logic [2:0] i);
        logic [9:0] c;
        unique case (i)
            3'd0:    c = 10'h145;
            3'd1:    c = 10'h14D;
            3'd2:    c = 10'h14E;
            3'd3:    c = 10'h14F;
            default: c = 10'h148;
        endcase
        return c;
    endfunction

endpackage

FILE: design/multitouch_dead_zone_filter_unit.sv
// top level of the multitouch dead zone filter
//
// input stream (s_*): one linux input event per request (type, code, value)
// output stream (m_*): zero to four events per input request, m_tlast marks
// the final one caused by that input; an input that yields nothing is silent
// apb port: left_edge, right_edge, top_edge at byte addresses 0, 4, 8
//
// pipeline: the input register holds one event, the slot table is read from
// a synchronous memory as the event moves to the execute stage, the
// execute stage updates the slot record and writes it back, and its results
// go into a four-entry output buffer that drains one event per cycle while m_tready is high
// throughput: one input per cycle while each yields at most one result and
// m_tready is high; an input with more results holds the execute stage until its run drains
// back-to-back events to one slot use a forward path around the memory
// reset: all slots read as inactive and zero through per-slot valid bits,
// slot zero is selected, no output slot is known yet, keys read as released
// a stall on m_tready holds the output buffer; the input register and the
// execute stage keep one event each before s_tready drops
module multitouch_dead_zone_filter_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // event_type[4:0], event_code[14:5], event_value[46:15], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_type[4:0], out_code[14:5], out_value[46:15], pad
    output logic        m_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LW = $clog2(SLOT_COUNT + 1);

    // configuration
    logic [31:0] left_reg, right_reg, top_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            top_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3:2] == mtdz_pkg::REG_LEFT)
                left_reg <= pwdata;
            if (paddr[3:2] == mtdz_pkg::REG_RIGHT)
                right_reg <= pwdata;
            if (paddr[3:2] == mtdz_pkg::REG_TOP)
                top_reg <= pwdata;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mtdz_pkg::REG_LEFT:  prdata = left_reg;
            mtdz_pkg::REG_RIGHT: prdata = right_reg;
            mtdz_pkg::REG_TOP:   prdata = top_reg;
            default:             prdata = '0;
        endcase
    end

    // pipeline registers
    logic               a_valid_reg;
    mtdz_pkg::event_t   a_ev_reg;
    logic               b_valid_reg;
    mtdz_pkg::event_t   b_ev_reg;

    // slot table memory with per-slot valid bits
    mtdz_pkg::slot_rec_t slot_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_vld_reg;
    mtdz_pkg::slot_rec_t mem_q_reg;
    logic               mem_vld_q_reg;
    logic               fwd_hit_reg;
    mtdz_pkg::slot_rec_t fwd_rec_reg;

    // frame and routing state
    logic          in_valid_reg, in_valid_next;
    logic [SW-1:0] in_idx_reg, in_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] out_idx_reg, out_idx_next;
    logic [LW-1:0] live_reg, live_next;
    logic          touch_reg, touch_next;
    logic [mtdz_pkg::TOOL_KINDS-1:0] tool_reg, tool_next;
    logic          frame_reg, frame_next;

    // output buffer
    mtdz_pkg::event_t res_reg [mtdz_pkg::MAX_RES];
    logic [2:0]    rem_reg;
    logic [1:0]    ptr_reg;

    logic          out_free;
    logic          b_fire;
    logic          a_move;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    mtdz_pkg::slot_rec_t wr_rec;
    mtdz_pkg::slot_rec_t rec;
    mtdz_pkg::event_t res_new [mtdz_pkg::MAX_RES];
    logic [2:0]    res_cnt;

    assign out_free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_tready);
    assign b_fire   = b_valid_reg && out_free;
    assign a_move   = a_valid_reg && (!b_valid_reg || b_fire);
    assign s_tready = !a_valid_reg || a_move;
    assign rd_addr  = b_fire ? in_idx_next : in_idx_reg;

    // record seen by the execute stage: forward, reset value, or memory
    always_comb
    begin
        priority if (fwd_hit_reg)
            rec = fwd_rec_reg;
        else if (!mem_vld_q_reg)
            rec = '0;
        else
            rec = mem_q_reg;
    end

    // execute stage
    always_comb
    begin
        mtdz_pkg::event_t cand [mtdz_pkg::CAND_N];
        logic [mtdz_pkg::CAND_N-1:0] cen;
        logic [4:0]  ty;
        logic [9:0]  cd;
        logic [31:0] val;
        logic        sel_need;
        logic        is_tool;
        logic        any_regen;
        logic        key_now;
        logic        outside;
        logic [2:0]  n;
        mtdz_pkg::slot_rec_t r;

        for (int k = 0; k < mtdz_pkg::CAND_N; k++)
        begin
            cand[k] = '0;
        end
        cen = '0;
        ty  = b_ev_reg.ev_type;
        cd  = b_ev_reg.ev_code;
        val = b_ev_reg.ev_value;
        r   = rec;
        sel_need = !out_valid_reg || (out_idx_reg != in_idx_reg);
        is_tool  = 1'b0;
        any_regen = 1'b0;
        key_now  = 1'b0;
        outside  = 1'b0;
        wr_en    = 1'b0;

        in_valid_next  = in_valid_reg;
        in_idx_next    = in_idx_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        live_next      = live_reg;
        touch_next     = touch_reg;
        tool_next      = tool_reg;
        frame_next     = frame_reg;

        if (b_valid_reg)
        begin
            if (ty == mtdz_pkg::T_SYN)
            begin
                if (cd == mtdz_pkg::C_SYN_REPORT)
                begin
                    // regenerate touch and finger keys from the live count
                    key_now = (live_reg != '0);
                    if (key_now != touch_reg)
                    begin
                        cen[0]  = 1'b1;
                        cand[0] = '{mtdz_pkg::T_KEY, mtdz_pkg::K_TOUCH, {31'd0, key_now}};
                        touch_next = key_now;
                    end
                    for (int i = 0; i < mtdz_pkg::TOOL_KINDS; i++)
                    begin
                        key_now = ({{(32-LW){1'b0}}, live_reg} == 32'(i + 1));
                        if (key_now != tool_reg[i])
                        begin
                            cen[i+1]  = 1'b1;
                            cand[i+1] = '{mtdz_pkg::T_KEY, mtdz_pkg::tool_code(3'(i)),
                                          {31'd0, key_now}};
                            tool_next[i] = key_now;
                        end
                    end
                    any_regen = |cen;
                    if (frame_reg || any_regen)
                    begin
                        cen[6]  = 1'b1;
                        cand[6] = '{mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 32'd0};
                    end
                end
                else if (frame_reg)
                begin
                    cen[0]  = 1'b1;
                    cand[0] = b_ev_reg;
                end
            end
            else if (ty == mtdz_pkg::T_ABS)
            begin
                if (cd == mtdz_pkg::C_SLOT)
                begin
                    if ($signed(val) < 0 || $signed(val) >= $signed(32'(SLOT_COUNT)))
                        in_valid_next = 1'b0;
                    else
                    begin
                        in_valid_next = 1'b1;
                        in_idx_next   = val[SW-1:0];
                    end
                end
                else if (cd == mtdz_pkg::C_TRACK)
                begin
                    if (in_valid_reg)
                    begin
                        wr_en = 1'b1;
                        if (r.mode == mtdz_pkg::MODE_LIVE)
                            live_next = live_reg - LW'(1);
                        if (val == mtdz_pkg::TRACK_RELEASE)
                        begin
                            if (r.emitted)
                            begin
                                cen[0]  = sel_need;
                                cand[0] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT,
                                            32'(in_idx_reg)};
                                cen[1]  = 1'b1;
                                cand[1] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK,
                                            mtdz_pkg::TRACK_RELEASE};
                            end
                            r = '0;
                        end
                        else
                        begin
                            r = '0;
                            r.mode = mtdz_pkg::MODE_PENDING;
                            r.track_id = val;
                        end
                    end
                end
                else if (cd == mtdz_pkg::C_PX || cd == mtdz_pkg::C_PY)
                begin
                    if (in_valid_reg)
                    begin
                        wr_en = 1'b1;
                        if (cd == mtdz_pkg::C_PX)
                        begin
                            r.pos_x  = val;
                            r.have_x = 1'b1;
                        end
                        else
                        begin
                            r.pos_y  = val;
                            r.have_y = 1'b1;
                        end
                        outside = ($signed(r.pos_x) < $signed(left_reg))
                               || ($signed(r.pos_x) > $signed(right_reg))
                               || ($signed(r.pos_y) < $signed(top_reg));
                        if (r.mode == mtdz_pkg::MODE_PENDING)
                        begin
                            if (r.have_x && r.have_y)
                            begin
                                if (outside)
                                    r.mode = mtdz_pkg::MODE_BLOCKED;
                                else
                                begin
                                    r.mode = mtdz_pkg::MODE_LIVE;
                                    live_next = live_reg + LW'(1);
                                    cen[0]  = sel_need;
                                    cand[0] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT,
                                                32'(in_idx_reg)};
                                    cen[1]  = !r.emitted;
                                    cand[1] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK,
                                                r.track_id};
                                    r.emitted = 1'b1;
                                    cen[2]  = 1'b1;
                                    cand[2] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_PX, r.pos_x};
                                    cen[3]  = 1'b1;
                                    cand[3] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_PY, r.pos_y};
                                end
                            end
                        end
                        else if (r.mode == mtdz_pkg::MODE_LIVE)
                        begin
                            cen[0]  = sel_need;
                            cand[0] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT,
                                        32'(in_idx_reg)};
                            cen[1]  = !r.emitted;
                            cand[1] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK, r.track_id};
                            r.emitted = 1'b1;
                            cen[2]  = 1'b1;
                            cand[2] = b_ev_reg;
                        end
                    end
                end
                else if (cd == mtdz_pkg::C_TMAJ || cd == mtdz_pkg::C_TMIN
                      || cd == mtdz_pkg::C_WMAJ || cd == mtdz_pkg::C_WMIN
                      || cd == mtdz_pkg::C_ORIENT || cd == mtdz_pkg::C_PRESS
                      || cd == mtdz_pkg::C_DIST)
                begin
                    if (in_valid_reg && r.mode == mtdz_pkg::MODE_LIVE && r.emitted)
                    begin
                        cen[0]  = sel_need;
                        cand[0] = '{mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, 32'(in_idx_reg)};
                        cen[1]  = 1'b1;
                        cand[1] = b_ev_reg;
                    end
                end
                else
                begin
                    cen[0]  = 1'b1;
                    cand[0] = b_ev_reg;
                end
            end
            else if (ty == mtdz_pkg::T_KEY)
            begin
                for (int i = 0; i < mtdz_pkg::TOOL_KINDS; i++)
                begin
                    if (cd == mtdz_pkg::tool_code(3'(i)))
                        is_tool = 1'b1;
                end
                if (!(cd == mtdz_pkg::K_TOUCH || is_tool))
                begin
                    cen[0]  = 1'b1;
                    cand[0] = b_ev_reg;
                end
            end
            else
            begin
                cen[0]  = 1'b1;
                cand[0] = b_ev_reg;
            end

            // a slot select candidate moves the output slot
            if (ty == mtdz_pkg::T_ABS && cd != mtdz_pkg::C_SLOT && cen[0]
                && cand[0].ev_code == mtdz_pkg::C_SLOT)
            begin
                out_valid_next = 1'b1;
                out_idx_next   = in_idx_reg;
            end

            if (ty == mtdz_pkg::T_SYN && cd == mtdz_pkg::C_SYN_REPORT)
                frame_next = 1'b0;
            else if (|cen)
                frame_next = 1'b1;
        end

        // pack the first four candidates in order
        n = 3'd0;
        for (int k = 0; k < mtdz_pkg::MAX_RES; k++)
        begin
            res_new[k] = '0;
        end
        for (int k = 0; k < mtdz_pkg::CAND_N; k++)
        begin
            if (cen[k] && n < 3'd4)
            begin
                res_new[n[1:0]] = cand[k];
                n = n + 3'd1;
            end
        end
        res_cnt = n;
        wr_rec  = r;
    end

    // slot memory: write back and one synchronous read
    always_ff @(posedge clk)
    begin
        if (b_fire && wr_en)
            slot_mem[in_idx_reg] <= wr_rec;
        mem_q_reg   <= slot_mem[rd_addr];
        fwd_rec_reg <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg  <= '0;
            mem_vld_q_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (b_fire && wr_en)
                slot_vld_reg[in_idx_reg] <= 1'b1;
            mem_vld_q_reg <= slot_vld_reg[rd_addr];
            fwd_hit_reg   <= b_fire && wr_en && (in_idx_reg == rd_addr);
        end
    end

    // pipeline control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            in_valid_reg  <= 1'b1;
            in_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            live_reg      <= '0;
            touch_reg     <= 1'b0;
            tool_reg      <= '0;
            frame_reg     <= 1'b0;
            rem_reg       <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;

            if (a_move)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;

            if (b_fire)
            begin
                in_valid_reg  <= in_valid_next;
                in_idx_reg    <= in_idx_next;
                out_valid_reg <= out_valid_next;
                out_idx_reg   <= out_idx_next;
                live_reg      <= live_next;
                touch_reg     <= touch_next;
                tool_reg      <= tool_next;
                frame_reg     <= frame_next;
                rem_reg       <= res_cnt;
                ptr_reg       <= '0;
            end
            else if (m_tvalid && m_tready)
            begin
                rem_reg <= rem_reg - 3'd1;
                ptr_reg <= ptr_reg + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            a_ev_reg <= '{s_tdata[4:0], s_tdata[14:5], s_tdata[46:15]};
        if (a_move)
            b_ev_reg <= a_ev_reg;
        if (b_fire)
        begin
            for (int k = 0; k < mtdz_pkg::MAX_RES; k++)
            begin
                res_reg[k] <= res_new[k];
            end
        end
    end

    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = {1'b0, res_reg[ptr_reg].ev_value, res_reg[ptr_reg].ev_code,
                       res_reg[ptr_reg].ev_type};
    assign m_tlast  = (rem_reg == 3'd1);

endmodule

FILE: design/mtdz_checker.sv
// port-level assertions for the multitouch dead zone filter, bound to the top level
module mtdz_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        pready
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

    // a run that has not ended continues with the next result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("run ended without last");

    // register port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
    else $error("apb wait state");

    // pad bit of the output stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[47])
    else $error("output pad bit set");

endmodule

bind multitouch_dead_zone_filter_unit mtdz_checker u_mtdz_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .pready   (pready)
);

FILE: dv/tb.sv
// testbench for the multitouch dead zone filter: predicts the output event stream and checks it
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected output event
    typedef struct packed {
        logic [4:0]  ev_type;
        logic [9:0]  ev_code;
        logic [31:0] ev_value;
        logic        last;
    } out_ev_t;

    // event filter predictor plus queue of pending output events
    class dead_zone_scoreboard;
        mtdz_pkg::mode_t mode[16];
        logic [31:0] trk[16];
        logic [31:0] px[16];
        logic [31:0] py[16];
        bit          hx[16];
        bit          hy[16];
        bit          shown[16];
        bit          in_ok;
        int          in_slot;
        bit          out_known;
        int          out_sel;
        bit          touch_sent;
        bit          tool_sent[5];
        bit          frame_busy;
        logic [31:0] left_x, right_x, top_y;
        out_ev_t     pending[$];
        out_ev_t     step_res[$];
        int          errors;

        function void reset_state();
            for (int i = 0; i < 16; i++) wipe_slot(i);
            in_ok = 1; in_slot = 0; out_known = 0; out_sel = 0;
            touch_sent = 0; frame_busy = 0;
            for (int i = 0; i < 5; i++) tool_sent[i] = 0;
            left_x = 0; right_x = 0; top_y = 0;
            errors = 0;
        endfunction

        function void wipe_slot(int s);
            mode[s] = mtdz_pkg::MODE_INACTIVE; trk[s] = 0; px[s] = 0; py[s] = 0;
            hx[s] = 0; hy[s] = 0; shown[s] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == mtdz_pkg::REG_LEFT) left_x = v;
            else if (idx == mtdz_pkg::REG_RIGHT) right_x = v;
            else if (idx == mtdz_pkg::REG_TOP) top_y = v;
        endfunction

        function void push(logic [4:0] t, logic [9:0] c, logic [31:0] v);
            out_ev_t e;
            e.ev_type = t; e.ev_code = c; e.ev_value = v; e.last = 0;
            if (step_res.size() < mtdz_pkg::MAX_RES) step_res.push_back(e);
            frame_busy = 1;
        endfunction

        function void pick_out(int s);
            if (!out_known || out_sel != s)
            begin
                push(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, s);
                out_known = 1; out_sel = s;
            end
        endfunction

        function void show(int s);
            if (!shown[s])
            begin
                pick_out(s);
                push(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK, trk[s]);
                shown[s] = 1;
            end
        endfunction

        function void decide(int s);
            if (mode[s] != mtdz_pkg::MODE_PENDING || !(hx[s] && hy[s])) return;
            if ($signed(px[s]) < $signed(left_x) || $signed(px[s]) > $signed(right_x)
                || $signed(py[s]) < $signed(top_y))
                mode[s] = mtdz_pkg::MODE_BLOCKED;
            else
            begin
                mode[s] = mtdz_pkg::MODE_LIVE;
                show(s);
                pick_out(s);
                push(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, px[s]);
                push(mtdz_pkg::T_ABS, mtdz_pkg::C_PY, py[s]);
            end
        endfunction

        function void refresh_keys();
            int live;
            bit w;
            live = 0;
            for (int i = 0; i < 16; i++) if (mode[i] == mtdz_pkg::MODE_LIVE) live++;
            if ((live > 0) != touch_sent)
            begin
                touch_sent = live > 0;
                push(mtdz_pkg::T_KEY, mtdz_pkg::K_TOUCH, {31'd0, touch_sent});
            end
            for (int i = 0; i < 5; i++)
            begin
                w = live == i + 1;
                if (w != tool_sent[i])
                begin
                    push(mtdz_pkg::T_KEY, mtdz_pkg::tool_code(i[2:0]), {31'd0, w});
                    tool_sent[i] = w;
                end
            end
        endfunction

        // note an accepted input request and queue its results
        function void note_request(mtdz_pkg::event_t ev);
            int s;
            bit is_tool;
            s = in_slot;
            step_res.delete();
            if (ev.ev_type == mtdz_pkg::T_SYN)
            begin
                if (ev.ev_code == mtdz_pkg::C_SYN_REPORT)
                begin
                    refresh_keys();
                    if (frame_busy) push(mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 0);
                    frame_busy = 0;
                end
                else if (frame_busy) push(ev.ev_type, ev.ev_code, ev.ev_value);
            end
            else if (ev.ev_type == mtdz_pkg::T_ABS)
            begin
                case (ev.ev_code)
                    mtdz_pkg::C_SLOT:
                        if ($signed(ev.ev_value) < 0 || $signed(ev.ev_value) >= 16) in_ok = 0;
                        else
                        begin
                            in_ok = 1; in_slot = ev.ev_value;
                        end
                    mtdz_pkg::C_TRACK:
                        if (in_ok)
                        begin
                            if (ev.ev_value == mtdz_pkg::TRACK_RELEASE)
                            begin
                                if (shown[s])
                                begin
                                    pick_out(s);
                                    push(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK,
                                         mtdz_pkg::TRACK_RELEASE);
                                end
                                wipe_slot(s);
                            end
                            else
                            begin
                                wipe_slot(s);
                                mode[s] = mtdz_pkg::MODE_PENDING;
                                trk[s] = ev.ev_value;
                            end
                        end
                    mtdz_pkg::C_PX, mtdz_pkg::C_PY:
                        if (in_ok)
                        begin
                            if (ev.ev_code == mtdz_pkg::C_PX)
                            begin
                                px[s] = ev.ev_value; hx[s] = 1;
                            end
                            else
                            begin
                                py[s] = ev.ev_value; hy[s] = 1;
                            end
                            if (mode[s] == mtdz_pkg::MODE_PENDING) decide(s);
                            else if (mode[s] == mtdz_pkg::MODE_LIVE)
                            begin
                                show(s);
                                pick_out(s);
                                push(mtdz_pkg::T_ABS, ev.ev_code, ev.ev_value);
                            end
                        end
                    mtdz_pkg::C_TMAJ, mtdz_pkg::C_TMIN, mtdz_pkg::C_WMAJ, mtdz_pkg::C_WMIN,
                    mtdz_pkg::C_ORIENT, mtdz_pkg::C_PRESS, mtdz_pkg::C_DIST:
                        if (in_ok && mode[s] == mtdz_pkg::MODE_LIVE && shown[s])
                        begin
                            pick_out(s);
                            push(mtdz_pkg::T_ABS, ev.ev_code, ev.ev_value);
                        end
                    default: push(ev.ev_type, ev.ev_code, ev.ev_value);
                endcase
            end
            else if (ev.ev_type == mtdz_pkg::T_KEY)
            begin
                is_tool = ev.ev_code == mtdz_pkg::K_TOUCH;
                for (int i = 0; i < 5; i++)
                    if (ev.ev_code == mtdz_pkg::tool_code(i[2:0])) is_tool = 1;
                if (!is_tool) push(ev.ev_type, ev.ev_code, ev.ev_value);
            end
            else push(ev.ev_type, ev.ev_code, ev.ev_value);
            if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1;
            foreach (step_res[i]) pending.push_back(step_res[i]);
        endfunction

        // compare one output event with the oldest expectation
        function void check_result(out_ev_t got);
            out_ev_t exp_ev;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected output event %h", got);
                return;
            end
            exp_ev = pending.pop_front();
            if (exp_ev != got)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp type %0d code %h value %h last %b,",
                              " got type %0d code %h value %h last %b"},
                        exp_ev.ev_type, exp_ev.ev_code, exp_ev.ev_value, exp_ev.last,
                        got.ev_type, got.ev_code, got.ev_value, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dead_zone_scoreboard board;
    int  cycles;
    bit  sink_hold;     // long receiver hold-off request
    bit  sink_quiet;    // receiver idling switched off for a stretch
    bit  src_quiet;

    multitouch_dead_zone_filter_unit #(.SLOT_COUNT(16)) DUT (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // output monitor: compare every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result({m_tdata[4:0], m_tdata[14:5], m_tdata[46:15], m_tlast});
    end

    // receiver: random ready gaps, plus a long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                sink_hold = 0;
            end
            gap = sink_quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.set_reg(idx, v);
    endtask

    // one input request, with optional random gap before it
    task automatic send_event(logic [4:0] t, logic [9:0] c, logic [31:0] v);
        mtdz_pkg::event_t ev;
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev.ev_type = t; ev.ev_code = c; ev.ev_value = v;
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, v, c, t};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_request(ev);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // a position drawn around the current dead zone edges
    function automatic logic [31:0] pick_pos(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return lo - 1;
            3: return hi + 1;
            4: return $urandom();
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // a touch in one slot: slot select, maybe id, maybe x and y, maybe shape, maybe pressure or distance, sync
    task automatic touch_frame();
        int s;
        s = $urandom_range(0, 15);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, s);
        if ($urandom_range(0, 3) != 0)
        begin
            send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK,
                       $urandom_range(0, 3) == 0 ? mtdz_pkg::TRACK_RELEASE
                                                 : $urandom_range(0, 9999));
        end
        if ($urandom_range(0, 1))
            send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, pick_pos(board.left_x, board.right_x));
        if ($urandom_range(0, 3) != 0)
            send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PY, pick_pos(board.top_y, board.top_y + 1000));
        if ($urandom_range(0, 1))
            send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, pick_pos(board.left_x, board.right_x));
        if ($urandom_range(0, 1))
            send_event(mtdz_pkg::T_ABS, 10'(mtdz_pkg::C_TMAJ + $urandom_range(0, 4)), $urandom());
        if ($urandom_range(0, 2) == 0)
            send_event(mtdz_pkg::T_ABS, $urandom_range(0, 1) ? mtdz_pkg::C_PRESS : mtdz_pkg::C_DIST,
                       $urandom());
        send_event(mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 0);
    endtask

    // stray events: odd types, codes, bad slots, incoming keys
    task automatic noise_event();
        case ($urandom_range(0, 6))
            0: send_event(5'($urandom()), 10'($urandom()), $urandom());
            1: send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT,
                          $urandom_range(0, 1) ? 16 + $urandom_range(0, 20)
                                               : 32'hFFFF_FFFF - $urandom_range(0, 5));
            2: send_event(mtdz_pkg::T_KEY,
                          $urandom_range(0, 1) ? mtdz_pkg::K_TOUCH
                                               : mtdz_pkg::tool_code(3'($urandom_range(0, 4))),
                          $urandom_range(0, 1));
            3: send_event(mtdz_pkg::T_KEY, 10'($urandom()), $urandom());
            4: send_event(mtdz_pkg::T_SYN, 10'($urandom_range(1, 1023)), $urandom());
            5: send_event(mtdz_pkg::T_ABS, 10'($urandom()), $urandom());
            default: send_event(mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 0);
        endcase
    endtask

    initial
    begin
        int sent;
        board = new();
        board.reset_state();
        cycles = 0;
        sink_hold = 0; sink_quiet = 0; src_quiet = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zone 100..900 in x, y from 50
        apb_write(mtdz_pkg::REG_LEFT, 100);
        apb_write(mtdz_pkg::REG_RIGHT, 900);
        apb_write(mtdz_pkg::REG_TOP, 50);
        // live touch in slot 0, then a pressure value
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK, 7);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, 100);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PY, 50);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PRESS, 33);
        send_event(mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 0);
        // blocked touch in slot 1 left of the zone, position ignored afterward
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, 1);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK, 32'h8000_0000);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PY, 32'h7FFF_FFFF);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, 99);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, 500);
        send_event(mtdz_pkg::T_SYN, 10'h3FF, 32'hFFFF_FFFF);
        // out of range slots drop per slot events
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, 16);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_PX, 200);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, 32'hFFFF_FFFF);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK, mtdz_pkg::TRACK_RELEASE);
        // incoming keys and pass-through
        send_event(mtdz_pkg::T_KEY, mtdz_pkg::K_TOUCH, 1);
        send_event(mtdz_pkg::T_KEY, 10'h3FF, 32'h7FFF_FFFF);
        send_event(5'h1F, 10'h3FF, 32'h8000_0000);
        send_event(mtdz_pkg::T_ABS, 10'h000, 5);
        // release slot 0
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_SLOT, 0);
        send_event(mtdz_pkg::T_ABS, mtdz_pkg::C_TRACK, mtdz_pkg::TRACK_RELEASE);
        send_event(mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 0);
        send_event(mtdz_pkg::T_SYN, mtdz_pkg::C_SYN_REPORT, 0);
        drain();

        // extremes of the zone, then random phases
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    apb_write(mtdz_pkg::REG_LEFT, 32'h8000_0000);
                    apb_write(mtdz_pkg::REG_RIGHT, 32'h7FFF_FFFF);
                    apb_write(mtdz_pkg::REG_TOP, 32'h8000_0000);
                end
                1:
                begin
                    apb_write(mtdz_pkg::REG_LEFT, 32'h7FFF_FFFF);
                    apb_write(mtdz_pkg::REG_RIGHT, 32'h8000_0000);
                    apb_write(mtdz_pkg::REG_TOP, 32'h7FFF_FFFF);
                end
                default:
                begin
                    apb_write(mtdz_pkg::REG_LEFT, $urandom_range(0, 800));
                    apb_write(mtdz_pkg::REG_RIGHT, $urandom_range(800, 2000));
                    apb_write(mtdz_pkg::REG_TOP, $urandom_range(0, 800));
                end
            endcase
            if (phase == 2)
            begin
                // long receiver stall while the source keeps offering
                sink_hold = 1;
                src_quiet = 1;
            end
            if (phase == 3) sink_quiet = 1;
            while (sent < 65 * (phase + 1))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    noise_event();
                    sent++;
                end
                else
                begin
                    touch_frame();
                    sent += 5;
                end
            end
            src_quiet = 0;
            sink_quiet = 0;
            drain();
        end

        while (board.pending.size() > 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: multitouch_dead_zone_filter_unit.f
design/mtdz_pkg.sv
design/multitouch_dead_zone_filter_unit.sv
design/mtdz_checker.sv
dv/tb.sv
